// ----- hw/rtl/tcw_pkg.sv -----
package tcw_pkg;

  // field widths fixed by the interface
  localparam int KIND_W = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int POS_W  = 11;
  localparam int CELL_W = CHAR_W + ATTR_W;

  // request kinds on the input port
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TILDE   = 8'h7E;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

  // classified command passed from front to back
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_PUT,
    CMD_NEWLINE,
    CMD_BACK,
    CMD_CLEAR,
    CMD_READ
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  cell_index;
  } cmd_req_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
  } res_t;

  // back end sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL
  } back_state_t;

  // what a fill sweep is for
  typedef enum logic [1:0] {
    FILL_INIT,
    FILL_CLEAR,
    FILL_ROW
  } fill_mode_t;

endpackage

// ----- hw/rtl/text_console_writer.sv -----
// path: command queue, back end, result queue; a cell read adds the store's registered read
// throughput: 1 request per cycle for put, newline, backspace and ignored bytes while the
// queues allow it and no scroll or clear runs; a cell read holds the back end in ST_READ
// until its result is pushed; a scroll copies each cell one row up, then blanks the bottom
// row, a clear blanks every cell, both via the single write port of the screen store
// reset: synchronous; the store is blanked in a pass over every cell, full stays high
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [KIND_W-1:0] kind,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [POS_W-1:0]  cell_index,
  output logic              empty,
  input  logic              pop,
  output logic [POS_W-1:0]  cursor_pos,
  output logic [CHAR_W-1:0] cell_char,
  output logic [ATTR_W-1:0] cell_attr,
  input  logic              cfg_write,
  input  logic [ATTR_W-1:0] text_attribute
);

  cmd_req_t                      fq_data;
  logic                          fq_push;
  logic                          cq_full;
  logic                          cq_empty;
  logic                          cq_pop;
  logic [$bits(cmd_req_t)-1:0]   cq_rbits;
  logic                          rq_full;
  logic                          rq_push;
  res_t                          rq_data;
  logic [$bits(res_t)-1:0]       rq_rbits;
  res_t                          res_out;
  logic                          init_busy;

  // request classification
  tcw_front u_front (
    .push       (push),
    .full       (full),
    .kind       (kind),
    .char_code  (char_code),
    .cell_index (cell_index),
    .hold       (init_busy),
    .q_full     (cq_full),
    .q_push     (fq_push),
    .q_data     (fq_data)
  );

  // command queue between front and back
  tcw_fifo #(
    .WIDTH($bits(cmd_req_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .wdata (fq_data),
    .full  (cq_full),
    .pop   (cq_pop),
    .rdata (cq_rbits),
    .empty (cq_empty)
  );

  // screen store and cursor
  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (text_attribute),
    .cmd_empty (cq_empty),
    .cmd_data  (cmd_req_t'(cq_rbits)),
    .cmd_pop   (cq_pop),
    .res_full  (rq_full),
    .res_push  (rq_push),
    .res_data  (rq_data),
    .init_busy (init_busy)
  );

  // result queue toward the consumer
  tcw_fifo #(
    .WIDTH($bits(res_t))
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .wdata (rq_data),
    .full  (rq_full),
    .pop   (pop),
    .rdata (rq_rbits),
    .empty (empty)
  );

  assign res_out    = res_t'(rq_rbits);
  assign cursor_pos = res_out.cursor_pos;
  assign cell_char  = res_out.cell_char;
  assign cell_attr  = res_out.cell_attr;

endmodule

// ----- hw/rtl/tcw_ram.sv -----
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/tcw_fifo.sv -----
module tcw_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// ----- hw/rtl/tcw_front.sv -----
module tcw_front import tcw_pkg::*; (
  input  logic              push,
  output logic              full,
  input  logic [KIND_W-1:0] kind,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [POS_W-1:0]  cell_index,
  input  logic              hold,
  input  logic              q_full,
  output logic              q_push,
  output cmd_req_t          q_data
);

  logic printable;

  // nothing enters while the queue is full or the screen is being initialized
  assign full   = q_full || hold;
  assign q_push = push && !full;

  assign printable = (char_code >= CHAR_SPACE) && (char_code <= CHAR_TILDE);

  // classify the request
  always_comb begin
    q_data.char_code  = char_code;
    q_data.cell_index = cell_index;
    unique case (kind)
      KIND_PUT: begin
        if (printable) begin
          q_data.cmd = CMD_PUT;
        end else if (char_code == CHAR_NEWLINE) begin
          q_data.cmd = CMD_NEWLINE;
        end else begin
          q_data.cmd = CMD_NOP;
        end
      end
      KIND_BACK:  q_data.cmd = CMD_BACK;
      KIND_CLEAR: q_data.cmd = CMD_CLEAR;
      KIND_READ:  q_data.cmd = CMD_READ;
      default:    q_data.cmd = CMD_NOP;
    endcase
  end

endmodule

// ----- hw/rtl/tcw_back.sv -----
module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [ATTR_W-1:0] cfg_data,
  input  logic              cmd_empty,
  input  cmd_req_t          cmd_data,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output res_t              res_data,
  output logic              init_busy
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int CW    = $clog2(CELLS);
  localparam int CLW   = $clog2(COLUMNS);

  localparam logic [CW-1:0]  LAST_CELL     = CW'(CELLS - 1);
  localparam logic [CW-1:0]  LAST_ROW_BASE = CW'(CELLS - COLUMNS);
  localparam logic [CW-1:0]  ROW_STEP      = CW'(COLUMNS);
  localparam logic [CLW-1:0] LAST_COL      = CLW'(COLUMNS - 1);

  back_state_t       state, state_next;
  fill_mode_t        fill_mode, fill_mode_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [CW-1:0]     src, src_next;
  logic [CW-1:0]     cursor, cursor_next;
  logic [CW-1:0]     row_base, row_base_next;
  logic [CLW-1:0]    col, col_next;
  logic [ATTR_W-1:0] attr;

  logic              ram_we;
  logic [CW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [CW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic [CELL_W-1:0] blank;
  logic              at_last;
  logic              on_bottom;
  logic              col_last;
  logic              read_ok;

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_write) begin
      attr <= cfg_data;
    end
  end

  // sequencer and cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      fill_mode <= FILL_INIT;
      cnt       <= '0;
      src       <= '0;
      cursor    <= '0;
      row_base  <= '0;
      col       <= '0;
    end else begin
      state     <= state_next;
      fill_mode <= fill_mode_next;
      cnt       <= cnt_next;
      src       <= src_next;
      cursor    <= cursor_next;
      row_base  <= row_base_next;
      col       <= col_next;
    end
  end

  assign blank     = {attr, CHAR_SPACE};
  assign at_last   = (cursor == LAST_CELL);
  assign on_bottom = (row_base == LAST_ROW_BASE);
  assign col_last  = (col == LAST_COL);
  assign read_ok   = (16'(cmd_data.cell_index) < 16'(CELLS));
  assign init_busy = (state == ST_FILL) && (fill_mode == FILL_INIT);

  // next state, store accesses and results
  always_comb begin
    state_next     = state;
    fill_mode_next = fill_mode;
    cnt_next       = cnt;
    src_next       = src;
    cursor_next    = cursor;
    row_base_next  = row_base;
    col_next       = col;
    ram_we         = 1'b0;
    ram_waddr      = cnt;
    ram_wdata      = blank;
    ram_raddr      = src;
    cmd_pop        = 1'b0;
    res_push       = 1'b0;
    res_data       = '{cursor_pos: POS_W'(cursor), cell_char: '0, cell_attr: '0};

    unique case (state)
      ST_IDLE: begin
        if (!cmd_empty && !res_full) begin
          unique case (cmd_data.cmd)
            CMD_NOP: begin
              res_push = 1'b1;
              cmd_pop  = 1'b1;
            end
            CMD_PUT: begin
              if (at_last) begin
                // scroll first, then the request is taken again
                state_next = ST_SCROLL;
                cnt_next   = '0;
                src_next   = ROW_STEP;
              end else begin
                ram_we      = 1'b1;
                ram_waddr   = cursor;
                ram_wdata   = {attr, cmd_data.char_code};
                cursor_next = cursor + 1'b1;
                if (col_last) begin
                  col_next      = '0;
                  row_base_next = row_base + ROW_STEP;
                end else begin
                  col_next = col + 1'b1;
                end
                res_data.cursor_pos = POS_W'(cursor_next);
                res_push = 1'b1;
                cmd_pop  = 1'b1;
              end
            end
            CMD_NEWLINE: begin
              if (on_bottom) begin
                state_next = ST_SCROLL;
                cnt_next   = '0;
                src_next   = ROW_STEP;
              end else begin
                row_base_next       = row_base + ROW_STEP;
                cursor_next         = row_base_next;
                col_next            = '0;
                res_data.cursor_pos = POS_W'(cursor_next);
                res_push = 1'b1;
                cmd_pop  = 1'b1;
              end
            end
            CMD_BACK: begin
              if (cursor != '0) begin
                cursor_next = cursor - 1'b1;
                if (col == '0) begin
                  col_next      = LAST_COL;
                  row_base_next = row_base - ROW_STEP;
                end else begin
                  col_next = col - 1'b1;
                end
              end
              ram_we              = 1'b1;
              ram_waddr           = cursor_next;
              ram_wdata           = blank;
              res_data.cursor_pos = POS_W'(cursor_next);
              res_push = 1'b1;
              cmd_pop  = 1'b1;
            end
            CMD_CLEAR: begin
              state_next     = ST_FILL;
              fill_mode_next = FILL_CLEAR;
              cnt_next       = '0;
            end
            CMD_READ: begin
              if (read_ok) begin
                ram_raddr  = CW'(cmd_data.cell_index);
                state_next = ST_READ;
              end else begin
                res_push = 1'b1;
                cmd_pop  = 1'b1;
              end
            end
            default: begin
              res_push = 1'b1;
              cmd_pop  = 1'b1;
            end
          endcase
        end
      end

      // read data returns in the cycle after the address is set
      ST_READ: begin
        res_data.cell_char = ram_rdata[CHAR_W-1:0];
        res_data.cell_attr = ram_rdata[CELL_W-1:CHAR_W];
        res_push   = 1'b1;
        cmd_pop    = 1'b1;
        state_next = ST_IDLE;
      end

      // copy each cell one row up: read ahead, write behind
      ST_SCROLL: begin
        ram_raddr = src;
        if (cnt != '0) begin
          ram_we    = 1'b1;
          ram_waddr = cnt - 1'b1;
          ram_wdata = ram_rdata;
        end
        if (cnt == LAST_ROW_BASE) begin
          state_next     = ST_FILL;
          fill_mode_next = FILL_ROW;
        end else begin
          cnt_next = cnt + 1'b1;
          src_next = src + 1'b1;
        end
      end

      // blank sweep up to the last cell
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = (fill_mode == FILL_INIT) ? {ATTR_RESET, CHAR_SPACE} : blank;
        if (cnt == LAST_CELL) begin
          state_next = ST_IDLE;
          case (fill_mode)
            FILL_CLEAR: begin
              cursor_next   = '0;
              row_base_next = '0;
              col_next      = '0;
              res_data.cursor_pos = '0;
              res_push = 1'b1;
              cmd_pop  = 1'b1;
            end
            FILL_ROW: begin
              cursor_next   = cursor - ROW_STEP;
              row_base_next = row_base - ROW_STEP;
            end
            default: begin
            end
          endcase
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
